### design/mbc3_pkg.sv
// Shared types and constants for the MBC3 bank controller and its checker.
package mbc3_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_ADDR_W = 22;
    localparam int RAM_ADDR_W = 15;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    localparam logic [7:0] RAM_ENABLE_KEY  = 8'h0A;
    localparam logic [7:0] MAX_RAM_SELECT  = 8'h07;
    localparam logic [7:0] ROM_BANK_RESET  = 8'h01;

    typedef enum logic [0:0] {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        TARGET_NONE = 2'd0,
        TARGET_ROM  = 2'd1,
        TARGET_RAM  = 2'd2
    } target_t;

    // Result item fields other than target, in tdata order.
    typedef struct packed {
        logic                  pad;
        logic                  bus_error;
        logic [RAM_ADDR_W-1:0] ram_address;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  ram_write;
    } result_t;

endpackage

### design/mbc3_bank_controller.sv
// MBC3 bank controller: bank registers and bus address translation.
// Result items are registered and appear in the cycle after their access is accepted.
// Throughput: one access per cycle unless the master side stalls; the decode and bank update
// are a single level of logic between the accepted access and the output register.
// Reset: rst_n clears asynchronously; ROM bank 1, RAM bank 0, RAM disabled, select 0,
// and the output register empty.
module mbc3_bank_controller
    import mbc3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // address[15:0], data[23:16]
    input  logic                   s_axis_tuser,   // op[0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // ram_write[0], rom_address[22:1],
                                                   // ram_address[37:23], bus_error[38], pad
    output logic [1:0]             m_axis_tuser    // target[1:0]
);

    logic [7:0]  rom_bank_reg, rom_bank_next;
    logic [1:0]  ram_bank_reg, ram_bank_next;
    logic        ram_on_reg, ram_on_next;
    logic [7:0]  select_reg, select_next;
    logic        valid_reg;
    result_t     result_reg, result_next;
    target_t     target_reg, target_next;

    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    op_t               op;
    logic              accept;
    logic              in_ram_window;
    logic              ram_mapped;
    logic [7:0]        rom_bank_low;

    assign address = s_axis_tdata[ADDR_W-1:0];
    assign data    = s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
    assign op      = op_t'(s_axis_tuser);

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_ram_window = (address[15:13] == 3'b101);
    assign ram_mapped    = (select_reg <= MAX_RAM_SELECT);
    assign rom_bank_low  = {rom_bank_reg[7], data[6:0]};

    always_comb
    begin
        rom_bank_next = rom_bank_reg;
        ram_bank_next = ram_bank_reg;
        ram_on_next   = ram_on_reg;
        select_next   = select_reg;
        target_next   = TARGET_NONE;
        result_next   = '0;

        if (op == OP_WRITE)
        begin
            if (address inside {[16'h0000:16'h1FFF]})
            begin
                ram_on_next = (data == RAM_ENABLE_KEY);
            end
            else if (address inside {[16'h2000:16'h3FFF]})
            begin
                // Bank 0 cannot be selected in the switchable window.
                rom_bank_next = (rom_bank_low == 8'h00) ? ROM_BANK_RESET : rom_bank_low;
            end
            else if (address inside {[16'h4000:16'h5FFF]})
            begin
                select_next = data;
                if (ram_on_reg)
                begin
                    ram_bank_next = data[1:0];
                end
                else
                begin
                    rom_bank_next = rom_bank_reg | {1'b0, data[1:0], 5'b0};
                end
            end
            else if (in_ram_window && ram_on_reg && ram_mapped)
            begin
                target_next             = TARGET_RAM;
                result_next.ram_write   = 1'b1;
                result_next.ram_address = {ram_bank_reg, address[12:0]};
            end
        end
        else
        begin
            if (address[15:14] == 2'b00)
            begin
                target_next             = TARGET_ROM;
                result_next.rom_address = {6'b0, address};
            end
            else if (address[15:14] == 2'b01)
            begin
                target_next             = TARGET_ROM;
                result_next.rom_address = {rom_bank_reg, address[13:0]};
            end
            else if (in_ram_window)
            begin
                if (ram_mapped)
                begin
                    target_next             = TARGET_RAM;
                    result_next.ram_address = {ram_bank_reg, address[12:0]};
                end
            end
            else
            begin
                result_next.bus_error = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg <= ROM_BANK_RESET;
            ram_bank_reg <= 2'd0;
            ram_on_reg   <= 1'b0;
            select_reg   <= 8'h00;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rom_bank_reg <= rom_bank_next;
                ram_bank_reg <= ram_bank_next;
                ram_on_reg   <= ram_on_next;
                select_reg   <= select_next;
                valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            target_reg <= target_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = result_reg;
    assign m_axis_tuser  = target_reg;

endmodule

### design/mbc3_checker.sv
// Port-level checker for the MBC3 bank controller, bound into each controller instance.
module mbc3_checker
    import mbc3_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    result_t res;
    assign res = m_axis_tdata;

    // A RAM store is always reported against the RAM target.
    a_store_is_ram: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.ram_write |-> m_axis_tuser == TARGET_RAM)
        else $error("ram_write set without RAM target");

    // A bus error never comes with a translated access.
    a_error_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.bus_error |-> m_axis_tuser == TARGET_NONE && !res.ram_write)
        else $error("bus_error with a target");

    // Address fields are zero outside their own target.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == TARGET_ROM || res.rom_address == '0)
                       && (m_axis_tuser == TARGET_RAM || res.ram_address == '0))
        else $error("stray physical address");

    // A stalled result item holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // The input side is open whenever the output register is free.
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

endmodule

bind mbc3_bank_controller mbc3_checker u_mbc3_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### verif/tb_mbc3_bank_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MBC3 bank controller stream interface.
module tb_mbc3_bank_controller;
    import mbc3_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        target_t target;
        result_t fields;
    } bus_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // address[15:0], data[23:16]
    logic                   s_axis_tuser = OP_READ;   // op[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // ram_write, rom_address, ram_address,
                                                 // bus_error, pad
    logic [1:0]             m_axis_tuser;        // target[1:0]

    // Bank state as the testbench expects it to be.
    logic [7:0] rom_bank_q;
    logic [1:0] ram_bank_q;
    logic       ram_on_q;
    logic [7:0] select_q;

    bus_result_t pending_results[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int sink_hold_len = 0;

    mbc3_bank_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("mbc3_bank_controller verification failed");
            $finish;
        end
    end

    // Updates the expected bank state and queues the result of one bus access.
    task automatic predict_bus_access(input op_t op, input logic [15:0] addr,
                                      input logic [7:0] data);
        bus_result_t r;
        logic [7:0]  bank;
        logic        in_ram_window;
        r = '0;
        r.target = TARGET_NONE;
        in_ram_window = (addr >= 16'hA000) && (addr <= 16'hBFFF);
        if (op == OP_WRITE)
        begin
            if (addr <= 16'h1FFF)
                ram_on_q = (data == RAM_ENABLE_KEY);
            else if (addr <= 16'h3FFF)
            begin
                bank = {rom_bank_q[7], data[6:0]};
                if (bank == 8'h00)
                    bank = ROM_BANK_RESET;
                rom_bank_q = bank;
            end
            else if (addr <= 16'h5FFF)
            begin
                select_q = data;
                // With RAM disabled the two bits land in the upper ROM bank bits.
                if (ram_on_q)
                    ram_bank_q = data[1:0];
                else
                    rom_bank_q = rom_bank_q | {1'b0, data[1:0], 5'b00000};
            end
            else if (in_ram_window && ram_on_q && select_q <= MAX_RAM_SELECT)
            begin
                r.target = TARGET_RAM;
                r.fields.ram_write = 1'b1;
                r.fields.ram_address = {ram_bank_q, addr[12:0]};
            end
        end
        else
        begin
            if (addr <= 16'h3FFF)
            begin
                r.target = TARGET_ROM;
                r.fields.rom_address = {6'b000000, addr};
            end
            else if (addr <= 16'h7FFF)
            begin
                r.target = TARGET_ROM;
                r.fields.rom_address = {rom_bank_q, addr[13:0]};
            end
            else if (in_ram_window)
            begin
                if (select_q <= MAX_RAM_SELECT)
                begin
                    r.target = TARGET_RAM;
                    r.fields.ram_address = {ram_bank_q, addr[12:0]};
                end
            end
            else
                r.fields.bus_error = 1'b1;
        end
        pending_results.push_back(r);
    endtask

    // Offers one item and returns at the clock edge that accepts it.
    task automatic send_access(input op_t op, input logic [15:0] addr,
                               input logic [7:0] data);
        logic taken;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {data, addr};
        s_axis_tuser <= op;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        predict_bus_access(op, addr, data);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly accesses into the decoded windows so the bank registers keep moving.
    task automatic random_bus_access();
        int          kind;
        logic [15:0] addr;
        logic [7:0]  data;
        op_t         op;
        kind = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        op = OP_WRITE;
        if (kind < 10)
        begin
            op = OP_READ;
            addr = 16'($urandom_range(0, 16'hFFFF));
        end
        else if (kind < 30)
        begin
            op = OP_READ;
            addr = 16'($urandom_range(0, 16'h7FFF));
        end
        else if (kind < 45)
        begin
            op = OP_READ;
            addr = 16'($urandom_range(16'hA000, 16'hBFFF));
        end
        else if (kind < 52)
        begin
            addr = 16'($urandom_range(0, 16'h1FFF));
            if ($urandom_range(0, 1) == 0)
                data = RAM_ENABLE_KEY;
        end
        else if (kind < 60)
            addr = 16'($urandom_range(16'h2000, 16'h3FFF));
        else if (kind < 68)
        begin
            addr = 16'($urandom_range(16'h4000, 16'h5FFF));
            if ($urandom_range(0, 3) != 0)
                data = 8'($urandom_range(0, 7));
        end
        else if (kind < 90)
            addr = 16'($urandom_range(16'hA000, 16'hBFFF));
        else
            addr = 16'($urandom_range(0, 16'hFFFF));
        send_access(op, addr, data);
    endtask

    task automatic test_reset_reads();
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_READ, 16'h3FFF, 8'hFF);
        send_access(OP_READ, 16'h4000, 8'h00);
        send_access(OP_READ, 16'h7FFF, 8'h00);
        send_access(OP_READ, 16'hA000, 8'h00);
        send_access(OP_READ, 16'hBFFF, 8'h00);
        send_access(OP_READ, 16'h8000, 8'h00);
        send_access(OP_READ, 16'h9FFF, 8'h00);
        send_access(OP_READ, 16'hC000, 8'h00);
        send_access(OP_READ, 16'hFFFF, 8'hFF);
        wait_drained();
    endtask

    task automatic test_bank_register_writes();
        // RAM store while disabled is dropped.
        send_access(OP_WRITE, 16'hA000, 8'h55);
        send_access(OP_WRITE, 16'h0000, RAM_ENABLE_KEY);
        send_access(OP_WRITE, 16'hBFFF, 8'hFF);
        // Bank 0 is promoted to bank 1.
        send_access(OP_WRITE, 16'h2000, 8'h00);
        send_access(OP_READ, 16'h4000, 8'h00);
        send_access(OP_WRITE, 16'h3FFF, 8'hFF);
        send_access(OP_READ, 16'h7FFF, 8'h00);
        send_access(OP_WRITE, 16'h4000, 8'h03);
        send_access(OP_READ, 16'hBFFF, 8'h00);
        // A select above 7 hides the RAM window on reads and writes.
        send_access(OP_WRITE, 16'h5FFF, 8'h08);
        send_access(OP_READ, 16'hA000, 8'h00);
        send_access(OP_WRITE, 16'hA000, 8'h12);
        send_access(OP_WRITE, 16'h6000, 8'hFF);
        send_access(OP_WRITE, 16'hFFFF, 8'hFF);
        send_access(OP_WRITE, 16'h1FFF, 8'h0B);
        send_access(OP_WRITE, 16'h2000, 8'h01);
        // With RAM disabled the bank range ORs into ROM bank bits 5 and 6.
        send_access(OP_WRITE, 16'h4000, 8'h02);
        send_access(OP_READ, 16'h4000, 8'h00);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        src_idle_pct = 0;
        @(negedge clk);
        sink_hold_len = HOLD_CYCLES;
        @(posedge clk);
        repeat (30)
            random_bus_access();
        wait_drained();
        repeat (10)
            random_bus_access();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count)
            random_bus_access();
        wait_drained();
    endtask

    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (sink_hold_len > 0)
            begin
                sink_hold_len = sink_hold_len - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Outputs are stable at the falling edge, so a handshake seen there is the one
    // that completes at the next rising edge.
    initial
    begin : result_checker
        bus_result_t want;
        result_t     got;
        target_t     got_target;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                got_target = target_t'(m_axis_tuser);
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result item: target %0d tdata %h",
                                 m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got_target !== want.target
                        || got.ram_write !== want.fields.ram_write
                        || got.rom_address !== want.fields.rom_address
                        || got.ram_address !== want.fields.ram_address
                        || got.bus_error !== want.fields.bus_error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("mismatch at cycle %0d", cycle_count);
                            $display("  expected target %0d wr %b rom %h ram %h err %b",
                                     want.target, want.fields.ram_write,
                                     want.fields.rom_address, want.fields.ram_address,
                                     want.fields.bus_error);
                            $display("  actual   target %0d wr %b rom %h ram %h err %b",
                                     m_axis_tuser, got.ram_write, got.rom_address,
                                     got.ram_address, got.bus_error);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        rom_bank_q = ROM_BANK_RESET;
        ram_bank_q = 2'b00;
        ram_on_q = 1'b0;
        select_q = 8'h00;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_reads();
        test_bank_register_writes();
        test_output_backpressure();
        test_random_traffic(28, 48, 170);
        test_random_traffic(48, 28, 170);
        test_random_traffic(0, 0, 160);

        wait_drained();
        repeat (5)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("mbc3_bank_controller verification clean");
        else
            $display("mbc3_bank_controller verification failed");
        $finish;
    end

endmodule
